// ===== hdl/bbms_pkg.sv =====
package bbms_pkg;

  // field widths
  localparam int unsigned PosW = 12;
  localparam int unsigned VelW = 24;
  localparam int unsigned ImpW = 16;
  localparam int unsigned DivW = 4;
  localparam int unsigned AccW = 8;
  localparam int unsigned WideW = VelW + 2;

  // divider: two quotient bits per cycle
  localparam int unsigned DivBitsPerStep = 2;
  localparam int unsigned DivSteps = VelW / DivBitsPerStep;
  localparam int unsigned DivCntW = $clog2(DivSteps);

  // register reset values
  localparam logic [DivW-1:0] DivisorReset   = 4'd2;
  localparam logic [AccW-1:0] FallAccelReset = 8'd9;
  localparam logic [PosW-1:0] LeftReset      = 12'd30;
  localparam logic [PosW-1:0] RightReset     = 12'd940;
  localparam logic [PosW-1:0] TopReset       = 12'd30;
  localparam logic [PosW-1:0] BottomReset    = 12'd480;
  localparam logic [PosW-1:0] StartXReset    = 12'd100;
  localparam logic [PosW-1:0] StartYReset    = 12'd100;

  localparam logic signed [WideW-1:0] VelMax = 26'sd8388607;
  localparam logic signed [WideW-1:0] VelMin = -26'sd8388608;

  typedef enum logic [2:0] {
    RegDivisor   = 3'd0,
    RegFallAccel = 3'd1,
    RegLeft      = 3'd2,
    RegRight     = 3'd3,
    RegTop       = 3'd4,
    RegBottom    = 3'd5,
    RegStartX    = 3'd6,
    RegStartY    = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic                   mode;
    logic signed [ImpW-1:0] impulse_x;
    logic signed [ImpW-1:0] impulse_y;
  } in_t;

  typedef struct packed {
    logic [PosW-1:0]        pos_x;
    logic [PosW-1:0]        pos_y;
    logic signed [VelW-1:0] vel_x;
    logic signed [VelW-1:0] vel_y;
    logic                   hit_top;
    logic                   hit_bottom;
    logic                   hit_left;
    logic                   hit_right;
  } out_t;

  typedef struct packed {
    logic [DivW-1:0] divisor;
    logic [AccW-1:0] fall_accel;
    logic [PosW-1:0] left_limit;
    logic [PosW-1:0] right_limit;
    logic [PosW-1:0] top_limit;
    logic [PosW-1:0] bottom_limit;
    logic [PosW-1:0] start_x;
    logic [PosW-1:0] start_y;
  } cfg_t;

  typedef struct packed {
    logic                   start;
    logic signed [VelW-1:0] dividend;
    logic [DivW-1:0]        divisor;
  } div_req_t;

  typedef struct packed {
    logic                   done;
    logic signed [VelW-1:0] quotient;
  } div_rsp_t;

  function automatic logic signed [WideW-1:0] ext_vel(input logic signed [VelW-1:0] v);
    ext_vel = {{(WideW-VelW){v[VelW-1]}}, v};
  endfunction

  function automatic logic signed [VelW-1:0] sat_vel(input logic signed [WideW-1:0] v);
    if (v > VelMax) begin
      sat_vel = VelMax[VelW-1:0];
    end else if (v < VelMin) begin
      sat_vel = VelMin[VelW-1:0];
    end else begin
      sat_vel = v[VelW-1:0];
    end
  endfunction

endpackage

// ===== hdl/bbms_regs.sv =====
module bbms_regs import bbms_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e idx;

  assign idx    = reg_idx_e'(paddr[4:2]);
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.divisor      <= DivisorReset;
      cfg_q.fall_accel   <= FallAccelReset;
      cfg_q.left_limit   <= LeftReset;
      cfg_q.right_limit  <= RightReset;
      cfg_q.top_limit    <= TopReset;
      cfg_q.bottom_limit <= BottomReset;
      cfg_q.start_x      <= StartXReset;
      cfg_q.start_y      <= StartYReset;
    end else if (psel && penable && pwrite) begin
      case (idx)
        RegDivisor:   cfg_q.divisor      <= pwdata[DivW-1:0];
        RegFallAccel: cfg_q.fall_accel   <= pwdata[AccW-1:0];
        RegLeft:      cfg_q.left_limit   <= pwdata[PosW-1:0];
        RegRight:     cfg_q.right_limit  <= pwdata[PosW-1:0];
        RegTop:       cfg_q.top_limit    <= pwdata[PosW-1:0];
        RegBottom:    cfg_q.bottom_limit <= pwdata[PosW-1:0];
        RegStartX:    cfg_q.start_x      <= pwdata[PosW-1:0];
        RegStartY:    cfg_q.start_y      <= pwdata[PosW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegDivisor:   prdata = 32'(cfg_q.divisor);
      RegFallAccel: prdata = 32'(cfg_q.fall_accel);
      RegLeft:      prdata = 32'(cfg_q.left_limit);
      RegRight:     prdata = 32'(cfg_q.right_limit);
      RegTop:       prdata = 32'(cfg_q.top_limit);
      RegBottom:    prdata = 32'(cfg_q.bottom_limit);
      RegStartX:    prdata = 32'(cfg_q.start_x);
      RegStartY:    prdata = 32'(cfg_q.start_y);
      default:      prdata = 32'd0;
    endcase
  end

endmodule

// ===== hdl/bbms_div.sv =====
module bbms_div import bbms_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                busy_q;
  logic                done_q;
  logic [DivCntW-1:0]  cnt_q;
  logic                neg_q;
  logic [VelW-1:0]     mag_q;
  logic [DivW-1:0]     rem_q;
  logic [VelW-1:0]     mag_d;
  logic [DivW-1:0]     rem_d;
  logic [DivW-1:0]     dvs;
  logic [VelW-1:0]     abs_in;

  // divisor of zero acts as one
  assign dvs    = (req_i.divisor == '0) ? DivW'(1) : req_i.divisor;
  assign abs_in = req_i.dividend[VelW-1] ? (~req_i.dividend + VelW'(1)) : req_i.dividend;

  // restoring division, dividend shifts out the top, quotient bits shift in
  always_comb begin
    logic [DivW:0] trial;
    mag_d = mag_q;
    rem_d = rem_q;
    for (int i = 0; i < DivBitsPerStep; i++) begin
      trial = {rem_d, mag_d[VelW-1]};
      mag_d = {mag_d[VelW-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        rem_d    = DivW'(trial - {1'b0, dvs});
        mag_d[0] = 1'b1;
      end else begin
        rem_d = trial[DivW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (req_i.start) begin
        busy_q <= 1'b1;
        done_q <= 1'b0;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q  <= cnt_q + DivCntW'(1);
        done_q <= (cnt_q == DivCntW'(DivSteps - 1));
        if (cnt_q == DivCntW'(DivSteps - 1)) begin
          busy_q <= 1'b0;
        end
      end else begin
        done_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      neg_q <= req_i.dividend[VelW-1];
      mag_q <= abs_in;
      rem_q <= '0;
    end else if (busy_q) begin
      mag_q <= mag_d;
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = neg_q ? signed'(~mag_q + VelW'(1)) : signed'(mag_q);

  start_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider started while busy");

endmodule

// ===== hdl/bouncing_ball_motion_step.sv =====
// channel   | direction | handshake                | payload
// ----------+-----------+--------------------------+--------------------------------
// input     | in        | in_valid_i / in_ready_o  | in_data_i  (mode, impulse_x/y)
// output    | out       | out_valid_o / out_ready_i| out_data_o (pos, vel, hit flags)
// config    | in        | psel/penable/pwrite      | paddr, pwdata, prdata, pready
//
// one transaction's length is set by the shared two-bit-per-cycle divider:
// it makes up to four divisions by the divisor per transaction
// reset loads the registers' reset values, the ball at (100, 100) and zero velocity
// a finished result sits in the output register; the next transaction is taken
// meanwhile and waits at the end of its step if that result is still not taken
module bouncing_ball_motion_step import bbms_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_X_CHK,
    S_X_Q1,
    S_X_Q2,
    S_Y_CHK,
    S_Y_Q1,
    S_Y_Q2,
    S_Y_FALL,
    S_FINISH
  } state_e;

  state_e state_q;

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // kept motion state
  logic signed [VelW-1:0] vx_q, vy_q;
  logic [PosW-1:0]        x_q, y_q;
  // step flags: which branch each axis took
  logic                   x_pos_q, y_up_q;
  logic                   hit_top_q, hit_bottom_q, hit_left_q, hit_right_q;
  // divider launch
  logic                   div_start_q;
  logic signed [VelW-1:0] div_a_q;
  // output register
  logic                   out_valid_q;
  out_t                   out_q;

  logic signed [WideW-1:0] fa_w;
  logic signed [WideW-1:0] q_w;
  logic signed [VelW-1:0]  vx_imp, vy_imp;
  logic signed [VelW:0]    q_half_sum;
  logic signed [VelW:0]    q_half;
  logic signed [VelW-1:0]  vx_damp, vy_damp;
  logic signed [WideW-1:0] nx, ny;
  logic [PosW-1:0]         x_new, y_new;
  logic signed [VelW-1:0]  vy_top, vy_bot, vy_fall;
  logic                    vx_pos, vx_neg, vy_pos, vy_neg;

  bbms_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign div_req.start    = div_start_q;
  assign div_req.dividend = div_a_q;
  assign div_req.divisor  = cfg.divisor;

  bbms_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign fa_w = signed'({{(WideW-AccW){1'b0}}, cfg.fall_accel});
  assign q_w  = ext_vel(div_rsp.quotient);

  // impulse: replace or add with saturation
  assign vx_imp = in_data_i.mode ? VelW'(in_data_i.impulse_x)
                : sat_vel(ext_vel(vx_q) + WideW'(in_data_i.impulse_x));
  assign vy_imp = in_data_i.mode ? VelW'(in_data_i.impulse_y)
                : sat_vel(ext_vel(vy_q) + WideW'(in_data_i.impulse_y));

  assign vx_pos = !vx_q[VelW-1] && (vx_q != '0);
  assign vx_neg = vx_q[VelW-1];
  assign vy_pos = !vy_q[VelW-1] && (vy_q != '0);
  assign vy_neg = vy_q[VelW-1];

  // quotient halved toward zero
  assign q_half_sum = signed'({div_rsp.quotient[VelW-1], div_rsp.quotient})
                    + signed'({{VelW{1'b0}}, div_rsp.quotient[VelW-1]});
  assign q_half     = q_half_sum >>> 1;

  assign vx_damp = sat_vel(ext_vel(vx_q) - WideW'(q_half));
  assign vy_damp = y_up_q ? sat_vel(ext_vel(vy_q) - q_w) : sat_vel(ext_vel(vy_q) + q_w);

  // moves clamped to the wall they head for
  assign nx = signed'({{(WideW-PosW){1'b0}}, x_q}) + q_w;
  assign ny = signed'({{(WideW-PosW){1'b0}}, y_q}) - q_w;

  always_comb begin
    if (x_pos_q) begin
      x_new = (nx >= signed'({{(WideW-PosW){1'b0}}, cfg.right_limit})) ? cfg.right_limit
            : nx[PosW-1:0];
    end else begin
      x_new = (nx <= signed'({{(WideW-PosW){1'b0}}, cfg.left_limit})) ? cfg.left_limit
            : nx[PosW-1:0];
    end
    if (y_up_q) begin
      y_new = (ny <= signed'({{(WideW-PosW){1'b0}}, cfg.top_limit})) ? cfg.top_limit
            : ny[PosW-1:0];
    end else begin
      y_new = (ny >= signed'({{(WideW-PosW){1'b0}}, cfg.bottom_limit})) ? cfg.bottom_limit
            : ny[PosW-1:0];
    end
  end

  // bounces and the fall term
  assign vy_top  = sat_vel(fa_w - ext_vel(vy_q));
  assign vy_bot  = sat_vel(-ext_vel(vy_q) - fa_w);
  assign vy_fall = sat_vel(ext_vel(vy_q) - fa_w);

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      vx_q         <= '0;
      vy_q         <= '0;
      x_q          <= StartXReset;
      y_q          <= StartYReset;
      x_pos_q      <= 1'b0;
      y_up_q       <= 1'b0;
      hit_top_q    <= 1'b0;
      hit_bottom_q <= 1'b0;
      hit_left_q   <= 1'b0;
      hit_right_q  <= 1'b0;
      div_start_q  <= 1'b0;
      div_a_q      <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      // launch pulse lasts one cycle, no launch can follow directly
      if (div_start_q) begin
        div_start_q <= 1'b0;
      end
      // the finishing step reloads the output register itself
      if (out_valid_q && out_ready_i && (state_q != S_FINISH)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            vx_q         <= vx_imp;
            vy_q         <= vy_imp;
            hit_top_q    <= 1'b0;
            hit_bottom_q <= 1'b0;
            hit_left_q   <= 1'b0;
            hit_right_q  <= 1'b0;
            state_q      <= S_X_CHK;
          end
        end
        S_X_CHK: begin
          x_pos_q <= vx_pos;
          if (vx_pos && (x_q >= cfg.right_limit)) begin
            hit_right_q <= 1'b1;
            vx_q        <= sat_vel(-ext_vel(vx_q));
            state_q     <= S_Y_CHK;
          end else if (vx_neg && (x_q <= cfg.left_limit)) begin
            hit_left_q <= 1'b1;
            vx_q       <= sat_vel(-ext_vel(vx_q));
            state_q    <= S_Y_CHK;
          end else if (vx_pos || vx_neg) begin
            // inside the box: damping divide first
            div_start_q <= 1'b1;
            div_a_q     <= vx_q;
            state_q     <= S_X_Q1;
          end else begin
            state_q <= S_Y_CHK;
          end
        end
        S_X_Q1: begin
          if (div_rsp.done) begin
            vx_q        <= vx_damp;
            div_start_q <= 1'b1;
            div_a_q     <= vx_damp;
            state_q     <= S_X_Q2;
          end
        end
        S_X_Q2: begin
          if (div_rsp.done) begin
            x_q     <= x_new;
            state_q <= S_Y_CHK;
          end
        end
        S_Y_CHK: begin
          y_up_q <= vy_pos;
          if (vy_pos && (y_q <= cfg.top_limit)) begin
            hit_top_q <= 1'b1;
            vy_q      <= vy_top;
            state_q   <= S_Y_FALL;
          end else if (vy_neg && (y_q >= cfg.bottom_limit)) begin
            hit_bottom_q <= 1'b1;
            vy_q         <= vy_bot;
            state_q      <= S_Y_FALL;
          end else if (vy_pos || vy_neg) begin
            div_start_q <= 1'b1;
            div_a_q     <= vy_q;
            state_q     <= S_Y_Q1;
          end else begin
            state_q <= S_Y_FALL;
          end
        end
        S_Y_Q1: begin
          if (div_rsp.done) begin
            vy_q        <= vy_damp;
            div_start_q <= 1'b1;
            div_a_q     <= vy_damp;
            state_q     <= S_Y_Q2;
          end
        end
        S_Y_Q2: begin
          if (div_rsp.done) begin
            y_q     <= y_new;
            state_q <= S_Y_FALL;
          end
        end
        S_Y_FALL: begin
          vy_q    <= vy_fall;
          state_q <= S_FINISH;
        end
        S_FINISH: begin
          // hand over once the output register is free
          if (!out_valid_q || out_ready_i) begin
            out_valid_q      <= 1'b1;
            out_q.pos_x      <= x_q;
            out_q.pos_y      <= y_q;
            out_q.vel_x      <= vx_q;
            out_q.vel_y      <= vy_q;
            out_q.hit_top    <= hit_top_q;
            out_q.hit_bottom <= hit_bottom_q;
            out_q.hit_left   <= hit_left_q;
            out_q.hit_right  <= hit_right_q;
            state_q          <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // divider results only arrive while a divide is awaited
  div_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_X_Q1 || state_q == S_X_Q2 ||
                      state_q == S_Y_Q1 || state_q == S_Y_Q2))
    else $error("unexpected divider result");

  busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken while a step is running");

  one_x_wall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.hit_left && out_data_o.hit_right))
    else $error("both side walls hit in one step");

  one_y_wall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.hit_top && out_data_o.hit_bottom))
    else $error("top and floor hit in one step");

endmodule

// ===== verif/bouncing_ball_motion_step_test.sv =====
`timescale 1ns / 1ps

module bouncing_ball_motion_step_test;
  import bbms_pkg::*;

  // clock and reset
  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk_i = ~clk_i;

  // step channel
  logic  in_valid = 1'b0;
  logic  in_ready;
  in_t   in_data  = '0;

  // motion result channel
  logic  out_valid;
  logic  out_ready = 1'b0;
  out_t  out_data;

  // register port
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [4:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  bouncing_ball_motion_step i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // ball state as the checker sees it, moved on every accepted step
  cfg_t   model_cfg;
  longint pos_x_now;
  longint pos_y_now;
  longint vel_x_now;
  longint vel_y_now;

  // results still owed by the block, oldest first
  out_t expected_motion[$];

  // idle odds in percent for the step sender and the result receiver
  int unsigned send_idle_pct = 34;
  int unsigned recv_idle_pct = 54;

  int unsigned mismatches    = 0;
  int unsigned steps_sent    = 0;
  int unsigned settings_used = 0;
  int unsigned walls_met     = 0;
  int unsigned saturated     = 0;

  // velocity saturation to the 24 bit signed range
  function automatic longint clamp_vel(input longint v);
    if (v > longint'(VelMax)) begin
      return longint'(VelMax);
    end
    if (v < longint'(VelMin)) begin
      return longint'(VelMin);
    end
    return v;
  endfunction

  // one motion tick: impulse first, then x, then y, then fall acceleration
  function automatic out_t next_motion(input in_t item);
    longint d;
    longint fa;
    longint lo_x;
    longint hi_x;
    longint lo_y;
    longint hi_y;
    longint ix;
    longint iy;
    out_t   r;
    d    = (model_cfg.divisor == '0) ? 64'sd1 : longint'(model_cfg.divisor);
    fa   = longint'(model_cfg.fall_accel);
    lo_x = longint'(model_cfg.left_limit);
    hi_x = longint'(model_cfg.right_limit);
    lo_y = longint'(model_cfg.top_limit);
    hi_y = longint'(model_cfg.bottom_limit);
    ix   = longint'(item.impulse_x);
    iy   = longint'(item.impulse_y);
    r    = '0;

    // mode 1 replaces the velocity outright, mode 0 accumulates
    if (item.mode) begin
      vel_x_now = ix;
      vel_y_now = iy;
    end else begin
      vel_x_now = clamp_vel(vel_x_now + ix);
      vel_y_now = clamp_vel(vel_y_now + iy);
    end

    // horizontal axis: damping by half of v/d, wall flips the sign
    if (vel_x_now > 0) begin
      if (pos_x_now < hi_x) begin
        vel_x_now = clamp_vel(vel_x_now - (vel_x_now / d) / 2);
        pos_x_now += vel_x_now / d;
        if (pos_x_now >= hi_x) pos_x_now = hi_x;
      end else begin
        r.hit_right = 1'b1;
        vel_x_now   = clamp_vel(-vel_x_now);
      end
    end else if (vel_x_now < 0) begin
      if (pos_x_now > lo_x) begin
        vel_x_now = clamp_vel(vel_x_now - (vel_x_now / d) / 2);
        pos_x_now += vel_x_now / d;
        if (pos_x_now <= lo_x) pos_x_now = lo_x;
      end else begin
        r.hit_left = 1'b1;
        vel_x_now  = clamp_vel(-vel_x_now);
      end
    end

    // vertical axis: up is positive velocity but smaller y
    if (vel_y_now > 0) begin
      if (pos_y_now > lo_y) begin
        vel_y_now = clamp_vel(vel_y_now - vel_y_now / d);
        pos_y_now -= vel_y_now / d;
        if (pos_y_now <= lo_y) pos_y_now = lo_y;
      end else begin
        r.hit_top = 1'b1;
        vel_y_now = clamp_vel(-vel_y_now + fa);
      end
    end else if (vel_y_now < 0) begin
      if (pos_y_now < hi_y) begin
        vel_y_now = clamp_vel(vel_y_now + vel_y_now / d);
        pos_y_now -= vel_y_now / d;
        if (pos_y_now >= hi_y) pos_y_now = hi_y;
      end else begin
        r.hit_bottom = 1'b1;
        vel_y_now    = clamp_vel(-vel_y_now - fa);
      end
    end

    // gravity every tick, after any bounce
    vel_y_now = clamp_vel(vel_y_now - fa);

    r.pos_x = pos_x_now[PosW-1:0];
    r.pos_y = pos_y_now[PosW-1:0];
    r.vel_x = vel_x_now[VelW-1:0];
    r.vel_y = vel_y_now[VelW-1:0];
    return r;
  endfunction

  // one field of a result against the oldest expectation
  task automatic compare_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // result side: random stalls on ready, every transaction checked in order
  always @(posedge clk_i) begin
    out_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_motion.size() == 0) begin
          $error("result transaction arrived with nothing pending");
          mismatches++;
        end else begin
          want = expected_motion.pop_front();
          compare_field("pos_x", longint'(want.pos_x), longint'(out_data.pos_x));
          compare_field("pos_y", longint'(want.pos_y), longint'(out_data.pos_y));
          compare_field("vel_x", longint'(want.vel_x), longint'(out_data.vel_x));
          compare_field("vel_y", longint'(want.vel_y), longint'(out_data.vel_y));
          compare_field("hit_top", longint'(want.hit_top), longint'(out_data.hit_top));
          compare_field("hit_bottom", longint'(want.hit_bottom),
                        longint'(out_data.hit_bottom));
          compare_field("hit_left", longint'(want.hit_left), longint'(out_data.hit_left));
          compare_field("hit_right", longint'(want.hit_right),
                        longint'(out_data.hit_right));
          walls_met += want.hit_top + want.hit_bottom + want.hit_left + want.hit_right;
          if (longint'(want.vel_x) == longint'(VelMax) ||
              longint'(want.vel_x) == longint'(VelMin) ||
              longint'(want.vel_y) == longint'(VelMax) ||
              longint'(want.vel_y) == longint'(VelMin)) begin
            saturated++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // one step transaction; valid stays up when the next one follows without a gap
  task automatic send_step(input in_t item);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk_i); while (!in_ready);
    expected_motion.push_back(next_motion(item));
    steps_sent++;
  endtask

  // drop valid and wait for every owed result, leaves us on a clock edge
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (expected_motion.size() != 0);
  endtask

  // register write: setup phase, access phase, then the port goes idle
  task automatic write_reg(input reg_idx_e idx, input logic [31:0] word);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    case (idx)
      RegDivisor:   model_cfg.divisor      = word[DivW-1:0];
      RegFallAccel: model_cfg.fall_accel   = word[AccW-1:0];
      RegLeft:      model_cfg.left_limit   = word[PosW-1:0];
      RegRight:     model_cfg.right_limit  = word[PosW-1:0];
      RegTop:       model_cfg.top_limit    = word[PosW-1:0];
      RegBottom:    model_cfg.bottom_limit = word[PosW-1:0];
      default:      ; // start position registers do not feed the motion step
    endcase
  endtask

  function automatic logic [31:0] noisy(input logic [31:0] field, input int unsigned w);
    logic [31:0] word;
    word = $urandom;
    word = (word & ~((32'd1 << w) - 32'd1)) | field;
    return word;
  endfunction

  // full register set, all eight written in index order
  task automatic write_setting(input cfg_t c);
    write_reg(RegDivisor,   noisy(32'(c.divisor), DivW));
    write_reg(RegFallAccel, noisy(32'(c.fall_accel), AccW));
    write_reg(RegLeft,      noisy(32'(c.left_limit), PosW));
    write_reg(RegRight,     noisy(32'(c.right_limit), PosW));
    write_reg(RegTop,       noisy(32'(c.top_limit), PosW));
    write_reg(RegBottom,    noisy(32'(c.bottom_limit), PosW));
    write_reg(RegStartX,    noisy(32'(c.start_x), PosW));
    write_reg(RegStartY,    noisy(32'(c.start_y), PosW));
    settings_used++;
  endtask

  // mostly ordered walls, now and then the wrong way round
  function automatic cfg_t random_setting();
    cfg_t c;
    c.divisor      = DivW'($urandom_range(15));
    c.fall_accel   = AccW'($urandom_range(255));
    c.left_limit   = PosW'($urandom_range(1500));
    c.right_limit  = PosW'($urandom_range(4095, 1500));
    c.top_limit    = PosW'($urandom_range(1500));
    c.bottom_limit = PosW'($urandom_range(4095, 1500));
    c.start_x      = PosW'($urandom_range(4095));
    c.start_y      = PosW'($urandom_range(4095));
    if ($urandom_range(4) == 0) begin
      {c.left_limit, c.right_limit} = {c.right_limit, c.left_limit};
    end
    if ($urandom_range(4) == 0) begin
      {c.top_limit, c.bottom_limit} = {c.bottom_limit, c.top_limit};
    end
    return c;
  endfunction

  // nudges keep the ball bouncing, the rest resets speed or hits every bit
  function automatic in_t random_motion_item();
    in_t         item;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70) begin
      item.mode      = 1'b0;
      item.impulse_x = ImpW'(int'($urandom_range(400)) - 200);
      item.impulse_y = ImpW'(int'($urandom_range(400)) - 200);
    end else if (pick < 80) begin
      item.mode      = 1'b1;
      item.impulse_x = ImpW'(int'($urandom_range(6000)) - 3000);
      item.impulse_y = ImpW'(int'($urandom_range(6000)) - 3000);
    end else begin
      item = in_t'({1'($urandom_range(1)), 32'($urandom)});
    end
    return item;
  endfunction

  function automatic in_t step_of(input logic m, input int x, input int y);
    in_t item;
    item.mode      = m;
    item.impulse_x = ImpW'(x);
    item.impulse_y = ImpW'(y);
    return item;
  endfunction

  // first tick straight out of reset shows the start position and defaults
  task automatic test_reset_defaults();
    send_step(step_of(1'b0, 0, 0));
    settle();
  endtask

  // impulse extremes in both modes and alternating bit patterns
  task automatic test_impulse_extremes();
    send_step(step_of(1'b1, 32767, -32768));
    send_step(step_of(1'b0, -32768, 32767));
    send_step(step_of(1'b1, -1, -1));
    send_step(step_of(1'b0, 1, 1));
    send_step(step_of(1'b1, 0, 0));
    send_step(step_of(1'b0, 'h5555, 'hAAAA));
    settle();
  endtask

  // drive the ball into each wall twice: once to clamp, once to bounce
  task automatic test_wall_hits();
    write_reg(RegLeft, 32'd200);
    write_reg(RegRight, 32'd300);
    write_reg(RegTop, 32'd200);
    write_reg(RegBottom, 32'd300);
    repeat (2) send_step(step_of(1'b1, 32767, 0));
    repeat (2) send_step(step_of(1'b1, -32768, 0));
    repeat (2) send_step(step_of(1'b1, 0, 32767));
    repeat (2) send_step(step_of(1'b1, 0, -32768));
    settle();
  endtask

  // divisor register at zero has to behave like one
  task automatic test_divisor_zero();
    write_reg(RegLeft, 32'd0);
    write_reg(RegRight, 32'd4095);
    write_reg(RegTop, 32'd0);
    write_reg(RegBottom, 32'd4095);
    write_reg(RegDivisor, 32'd0);
    send_step(step_of(1'b1, 1000, 1000));
    send_step(step_of(1'b0, -3000, -3000));
    send_step(step_of(1'b0, 50, -50));
    settle();
  endtask

  // walls given the wrong way round still keep the ball inside 0..4095
  task automatic test_swapped_limits();
    write_reg(RegDivisor, 32'd3);
    write_reg(RegLeft, 32'd3000);
    write_reg(RegRight, 32'd1000);
    write_reg(RegTop, 32'd3000);
    write_reg(RegBottom, 32'd1000);
    send_step(step_of(1'b1, 700, -700));
    send_step(step_of(1'b1, -700, 700));
    send_step(step_of(1'b0, 4000, 4000));
    send_step(step_of(1'b0, -9000, -9000));
    settle();
  endtask

  // crossed walls make every tick a pure bounce with no damping, so impulses
  // matched to the current sign pump speed up until both axes saturate
  task automatic test_velocity_saturation();
    in_t item;
    settle();
    write_reg(RegDivisor, 32'($urandom_range(15)));
    write_reg(RegFallAccel, 32'($urandom_range(15)));
    write_reg(RegLeft, 32'd4095);
    write_reg(RegRight, 32'd0);
    write_reg(RegTop, 32'd4095);
    write_reg(RegBottom, 32'd0);
    settings_used++;
    repeat (380) begin
      if ($urandom_range(9) == 0) begin
        item = random_motion_item();
        item.mode = 1'b0;
      end else begin
        item.mode = 1'b0;
        item.impulse_x = (vel_x_now >= 0) ? ImpW'(int'($urandom_range(32767, 24576)))
                                          : ImpW'(-int'($urandom_range(32768, 24576)));
        item.impulse_y = (vel_y_now >= 0) ? ImpW'(int'($urandom_range(32767, 24576)))
                                          : ImpW'(-int'($urandom_range(32768, 24576)));
      end
      send_step(item);
    end
    settle();
  endtask

  // one idle pattern, one extreme setting then random ones, 50 ticks each
  task automatic test_random_motion(input int unsigned snd_pct, input int unsigned rcv_pct,
                                    input cfg_t extreme);
    settle();
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    for (int blk = 0; blk < 4; blk++) begin
      settle();
      write_setting((blk == 0) ? extreme : random_setting());
      repeat (50) send_step(random_motion_item());
    end
    settle();
  endtask

  // main sequence
  initial begin
    cfg_t corner_a;
    cfg_t corner_b;
    cfg_t corner_c;

    // predictor starts from the register reset values
    model_cfg = '{divisor: DivisorReset, fall_accel: FallAccelReset,
                  left_limit: LeftReset, right_limit: RightReset,
                  top_limit: TopReset, bottom_limit: BottomReset,
                  start_x: StartXReset, start_y: StartYReset};
    pos_x_now = longint'(StartXReset);
    pos_y_now = longint'(StartYReset);
    vel_x_now = 0;
    vel_y_now = 0;

    // widest box, zero divisor, heaviest ball
    corner_a = '{divisor: 4'd0, fall_accel: 8'd255, left_limit: 12'd0,
                 right_limit: 12'd4095, top_limit: 12'd0, bottom_limit: 12'd4095,
                 start_x: 12'd0, start_y: 12'd4095};
    // box shrunk to a point, weakest damping, no gravity
    corner_b = '{divisor: 4'd15, fall_accel: 8'd0, left_limit: 12'd2048,
                 right_limit: 12'd2048, top_limit: 12'd2048, bottom_limit: 12'd2048,
                 start_x: 12'd4095, start_y: 12'd0};
    // divisor one, fast growth while falling
    corner_c = '{divisor: 4'd1, fall_accel: 8'd128, left_limit: 12'd4095,
                 right_limit: 12'd4095, top_limit: 12'd0, bottom_limit: 12'd0,
                 start_x: 12'd100, start_y: 12'd100};

    repeat (4) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // directed part under the first idle pattern
    send_idle_pct = 34;
    recv_idle_pct = 54;
    test_reset_defaults();
    test_impulse_extremes();
    test_wall_hits();
    test_divisor_zero();
    test_swapped_limits();

    // random part: idle patterns as planned, saturation pump in the middle
    test_random_motion(34, 54, corner_a);
    test_random_motion(54, 34, corner_b);
    test_velocity_saturation();
    test_random_motion(0, 0, corner_c);

    // let any stray result show up before judging
    settle();
    repeat (100) @(posedge clk_i);
    if (expected_motion.size() != 0) begin
      $error("%0d results never arrived", expected_motion.size());
      mismatches++;
    end

    $display("run covered %0d step transactions over %0d register settings",
             steps_sent, settings_used);
    $display("walls met %0d times, saturated velocity seen in %0d results",
             walls_met, saturated);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // hang guard, far above the slowest legal run
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/bbms_pkg.sv
hdl/bbms_regs.sv
hdl/bbms_div.sv
hdl/bouncing_ball_motion_step.sv
verif/bouncing_ball_motion_step_test.sv
